/* design/dtc_pkg.sv */
// Shared types and constants for the decision tree classifier.
`timescale 1ns / 1ps
`default_nettype none

package dtc_pkg;

	// Request kinds carried in req_type.
	localparam logic REQ_WRITE    = 1'b0;
	localparam logic REQ_CLASSIFY = 1'b1;

	// Attributes carried by a classify item.
	localparam int NUM_ATTRS = 4;

	typedef struct packed {
		logic               req_type;
		logic [7:0]         node_addr;
		logic               node_is_leaf;
		logic [1:0]         split_attr;
		logic signed [15:0] split_value;
		logic [7:0]         left_child;
		logic [7:0]         right_child;
		logic [3:0]         leaf_class;
		logic signed [15:0] attr_0;
		logic signed [15:0] attr_1;
		logic signed [15:0] attr_2;
		logic signed [15:0] attr_3;
	} req_t;

	typedef struct packed {
		logic [3:0] predicted_class;
		logic [7:0] leaf_index;
		logic       walk_error;
	} rsp_t;

	typedef struct packed {
		logic               is_leaf;
		logic [1:0]         split_attr;
		logic signed [15:0] split_value;
		logic [7:0]         left_child;
		logic [7:0]         right_child;
		logic [3:0]         leaf_class;
	} node_t;

	typedef struct packed {
		logic  written;
		node_t node;
	} entry_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_wr;
		logic node_wr;
		logic start;
		logic step;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic req_classify;
		logic walk_done;
	} status_t;

endpackage

`default_nettype wire

/* design/dtc_chan_if.sv */
// Valid/ready channel interface carrying one payload item.
`timescale 1ns / 1ps
`default_nettype none

interface dtc_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/dtc_datapath.sv */
// Datapath: node memory, walk registers, compare and result register.
`timescale 1ns / 1ps
`default_nettype none

module dtc_datapath #(
	parameter int MAX_NODES = 256,
	parameter int MAX_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dtc_pkg::req_t    req_data,
	input  dtc_pkg::cmd_t    cmd,
	output dtc_pkg::status_t status,
	output dtc_pkg::rsp_t    rsp_data
);
	import dtc_pkg::*;

	localparam int AW = $clog2(MAX_NODES);
	localparam int SW = $clog2(MAX_DEPTH + 1);

	entry_t             node_mem_q [MAX_NODES];
	entry_t             rd_q;
	logic [AW-1:0]      clr_cnt_q;
	logic signed [15:0] attrs_q [NUM_ATTRS];
	logic [7:0]         cur_q;
	logic               oob_q;
	logic [SW-1:0]      steps_q;
	rsp_t               rsp_q;

	logic          we;
	logic [AW-1:0] waddr;
	entry_t        wdata;
	logic          re;
	logic [AW-1:0] raddr;
	logic          addr_ok;
	logic          node_ok;
	logic          fail;
	logic          go_left;
	logic [7:0]    next_idx;
	rsp_t          res;

	assign addr_ok = 32'(req_data.node_addr) < MAX_NODES;

	always_comb begin
		we    = cmd.clr_wr || (cmd.node_wr && addr_ok);
		waddr = cmd.clr_wr ? clr_cnt_q : AW'(req_data.node_addr);
		wdata = '0;
		if (!cmd.clr_wr) begin
			wdata.written          = 1'b1;
			wdata.node.is_leaf     = req_data.node_is_leaf;
			wdata.node.split_attr  = req_data.split_attr;
			wdata.node.split_value = req_data.split_value;
			wdata.node.left_child  = req_data.left_child;
			wdata.node.right_child = req_data.right_child;
			wdata.node.leaf_class  = req_data.leaf_class;
		end
	end

	// A child index past the table counts as an unwritten node.
	assign node_ok  = rd_q.written && !oob_q;
	assign go_left  = attrs_q[rd_q.node.split_attr] < rd_q.node.split_value;
	assign next_idx = go_left ? rd_q.node.left_child : rd_q.node.right_child;
	assign fail     = !node_ok || (!rd_q.node.is_leaf &&
		(steps_q >= SW'(MAX_DEPTH) || 32'(rd_q.node.split_attr) >= NUM_ATTRS));

	always_comb begin
		res = '0;
		if (fail) begin
			res.walk_error = 1'b1;
		end else begin
			res.predicted_class = rd_q.node.leaf_class;
			res.leaf_index      = cur_q;
		end
	end

	assign re    = cmd.start || cmd.step;
	assign raddr = cmd.start ? '0 : AW'(next_idx);

	always_ff @(posedge clk) begin
		if (we) begin
			node_mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= node_mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			attrs_q[0] <= req_data.attr_0;
			attrs_q[1] <= req_data.attr_1;
			attrs_q[2] <= req_data.attr_2;
			attrs_q[3] <= req_data.attr_3;
			cur_q      <= '0;
			oob_q      <= 1'b0;
			steps_q    <= '0;
		end else if (cmd.step) begin
			cur_q   <= next_idx;
			oob_q   <= !(32'(next_idx) < MAX_NODES);
			steps_q <= steps_q + SW'(1);
		end
		if (cmd.load_out) begin
			rsp_q <= res;
		end
	end

	assign status.clr_last     = clr_cnt_q == AW'(MAX_NODES - 1);
	assign status.req_classify = req_data.req_type == REQ_CLASSIFY;
	assign status.walk_done    = fail || rd_q.node.is_leaf;
	assign rsp_data            = rsp_q;

endmodule

`default_nettype wire

/* design/dtc_controller.sv */
// Controller: clearing pass, request acceptance, walk sequencing, output handshake.
`timescale 1ns / 1ps
`default_nettype none

module dtc_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	input  dtc_pkg::status_t status,
	output dtc_pkg::cmd_t    cmd
);
	import dtc_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (status.req_classify) begin
						cmd.start = 1'b1;
						state_d   = ST_WALK;
					end else begin
						cmd.node_wr = 1'b1;
					end
				end
			end
			ST_WALK: begin
				// A finished walk holds until the output register is free.
				if (!status.walk_done) begin
					cmd.step = 1'b1;
				end else if (!out_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

`default_nettype wire

/* design/decision_tree_classifier.sv */
// Top level of the decision tree classifier: controller, datapath and checks.
//
// The req channel takes two kinds of item. A write item loads one node of
// the tree table and produces no result; req stays ready after it. A
// classify item walks the tree from node 0 with its four attributes and
// produces exactly one item on the rsp channel.
// A classify item is accepted and then walks the tree step by step; each
// step is one read of the node memory followed by one signed compare
// that picks the next address. A walk visits between one and
// MAX_DEPTH + 1 nodes. Req is not ready again until the result of the
// last node is loaded into the output register, which drives rsp.
// After reset the block runs a clearing pass over every entry of the
// node memory, during which req is not ready.
// The result sits in an output register, so a new item is accepted while
// rsp stalls. A walk that finishes while the previous result is still not
// taken waits with its result until rsp takes the older one.
`timescale 1ns / 1ps
`default_nettype none

module decision_tree_classifier #(
	parameter int MAX_NODES = 256,
	parameter int MAX_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	dtc_chan_if.sink   req,
	dtc_chan_if.source rsp
);
	import dtc_pkg::*;

	cmd_t    cmd;
	status_t status;

	dtc_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	dtc_datapath #(
		.MAX_NODES (MAX_NODES),
		.MAX_DEPTH (MAX_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req.data),
		.cmd      (cmd),
		.status   (status),
		.rsp_data (rsp.data)
	);

	// At most one command is issued in any cycle.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("controller issued more than one command");

	// A result is never loaded over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp.valid || rsp.ready))
		else $error("result register overwritten");

	// An accepted classify item makes the block busy in the next cycle.
	a_busy_after_classify: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.data.req_type == REQ_CLASSIFY) |=> !req.ready)
		else $error("request taken during a walk");

	// A failed walk reports zero class and zero index.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.walk_error) |->
		(rsp.data.predicted_class == '0 && rsp.data.leaf_index == '0))
		else $error("error result carries a class or index");

endmodule

`default_nettype wire

/* tb/sv/dtc_checker.sv */
// Checker for the decision tree classifier: tracks the node table, predicts and compares results.
`timescale 1ns / 1ps

module dtc_checker #(
	parameter int MAX_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  dtc_pkg::req_t req_data,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  dtc_pkg::rsp_t rsp_data,
	output int            mismatches,
	output int            outstanding
);
	import dtc_pkg::*;

	node_t      tree_nodes [256];
	bit [255:0] node_loaded = '0;
	rsp_t       pending_results [$];
	int         fail_tally = 0;
	int         queued = 0;

	assign mismatches  = fail_tally;
	assign outstanding = queued;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_tally++;
	endtask

	// Walks the tree from the root exactly as the block should for one classify item.
	function automatic rsp_t walk_tree(input req_t q);
		logic signed [15:0] attr [NUM_ATTRS];
		logic [7:0]         cur_node;
		node_t              n;
		rsp_t               failed;
		attr[0] = q.attr_0;
		attr[1] = q.attr_1;
		attr[2] = q.attr_2;
		attr[3] = q.attr_3;
		failed = '0;
		failed.walk_error = 1'b1;
		cur_node = '0;
		for (int hop = 0; hop <= MAX_DEPTH; hop++) begin
			if (!node_loaded[cur_node])
				return failed;
			n = tree_nodes[cur_node];
			if (n.is_leaf)
				return '{predicted_class: n.leaf_class, leaf_index: cur_node, walk_error: 1'b0};
			if (int'(n.split_attr) >= NUM_ATTRS)
				return failed;
			cur_node = ($signed(attr[n.split_attr]) < $signed(n.split_value)) ?
				n.left_child : n.right_child;
		end
		// Still on a branch once the depth budget is spent.
		return failed;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t  want;
		node_t fresh;
		if (!arst_n) begin
			node_loaded = '0;
			pending_results.delete();
			queued = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result class %0d leaf %0d error %0b",
						rsp_data.predicted_class, rsp_data.leaf_index, rsp_data.walk_error));
				end else begin
					want = pending_results.pop_front();
					if (rsp_data.predicted_class !== want.predicted_class)
						report_mismatch($sformatf("predicted_class got %0d want %0d",
							rsp_data.predicted_class, want.predicted_class));
					if (rsp_data.leaf_index !== want.leaf_index)
						report_mismatch($sformatf("leaf_index got %0d want %0d",
							rsp_data.leaf_index, want.leaf_index));
					if (rsp_data.walk_error !== want.walk_error)
						report_mismatch($sformatf("walk_error got %0b want %0b",
							rsp_data.walk_error, want.walk_error));
				end
			end
			if (req_valid && req_ready) begin
				if (req_data.req_type == REQ_CLASSIFY) begin
					pending_results = {pending_results, walk_tree(req_data)};
				end else begin
					// A leaf keeps only its class; a branch drops the class field.
					fresh = '0;
					fresh.is_leaf = req_data.node_is_leaf;
					if (req_data.node_is_leaf) begin
						fresh.leaf_class = req_data.leaf_class;
					end else begin
						fresh.split_attr  = req_data.split_attr;
						fresh.split_value = req_data.split_value;
						fresh.left_child  = req_data.left_child;
						fresh.right_child = req_data.right_child;
					end
					tree_nodes[req_data.node_addr]  = fresh;
					node_loaded[req_data.node_addr] = 1'b1;
				end
			end
			queued = pending_results.size();
		end
	end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top for the decision tree classifier: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;
	import dtc_pkg::*;

	localparam int TREE_NODES   = 256;
	localparam int WALK_LIMIT   = 16;
	localparam int RANDOM_ITEMS = 1150;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 40;
	// Nodes in this range are never loaded, so a child pointing here ends the walk with an error.
	localparam int SPARE_LO = 240;
	localparam int SPARE_HI = 254;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_count;
	int   items_sent;
	int   cycle_count;
	bit   calm_phase;
	bit [TREE_NODES-1:0] in_tree;
	logic signed [15:0]  thr_seen [$];

	dtc_chan_if #(.T(req_t)) req_if ();
	dtc_chan_if #(.T(rsp_t)) rsp_if ();

	decision_tree_classifier #(
		.MAX_NODES(TREE_NODES),
		.MAX_DEPTH(WALK_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	dtc_checker #(
		.MAX_DEPTH(WALK_LIMIT)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_if.valid),
		.req_ready(req_if.ready),
		.req_data(req_if.data),
		.rsp_valid(rsp_if.valid),
		.rsp_ready(rsp_if.ready),
		.rsp_data(rsp_if.data),
		.mismatches(fail_count),
		.outstanding(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	function automatic req_t noise_req();
		logic [127:0] raw;
		raw = {$urandom(), $urandom(), $urandom(), $urandom()};
		return raw[$bits(req_t)-1:0];
	endfunction

	function automatic req_t make_leaf(input logic [7:0] addr, input logic [3:0] cls);
		req_t r;
		r = noise_req();
		r.req_type     = REQ_WRITE;
		r.node_addr    = addr;
		r.node_is_leaf = 1'b1;
		r.leaf_class   = cls;
		return r;
	endfunction

	function automatic req_t make_branch(input logic [7:0] addr, input logic [1:0] attr,
			input logic signed [15:0] thr, input logic [7:0] lc, input logic [7:0] rc);
		req_t r;
		r = noise_req();
		r.req_type     = REQ_WRITE;
		r.node_addr    = addr;
		r.node_is_leaf = 1'b0;
		r.split_attr   = attr;
		r.split_value  = thr;
		r.left_child   = lc;
		r.right_child  = rc;
		return r;
	endfunction

	function automatic req_t make_query(input logic signed [15:0] a0, input logic signed [15:0] a1,
			input logic signed [15:0] a2, input logic signed [15:0] a3);
		req_t r;
		r = noise_req();
		r.req_type = REQ_CLASSIFY;
		r.attr_0   = a0;
		r.attr_1   = a1;
		r.attr_2   = a2;
		r.attr_3   = a3;
		return r;
	endfunction

	// Thresholds lean toward the extremes and are remembered so queries can land on them.
	function automatic logic signed [15:0] pick_threshold();
		logic signed [15:0] thr;
		case ($urandom_range(0, 7))
			0: thr = 16'sh8000;
			1: thr = 16'sh7fff;
			2: thr = '0;
			default: thr = 16'($urandom);
		endcase
		thr_seen = {thr_seen, thr};
		return thr;
	endfunction

	function automatic logic signed [15:0] pick_attr();
		logic signed [15:0] base;
		int off;
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			3: return 16'shffff;
			4, 5, 6: begin
				if (thr_seen.size() == 0)
					return 16'($urandom);
				base = thr_seen[$urandom_range(0, thr_seen.size() - 1)];
				off = $urandom_range(0, 2);
				return 16'(base + off - 1);
			end
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] fresh_addr();
		int unsigned a;
		do a = $urandom_range(1, SPARE_LO - 1); while (in_tree[a]);
		in_tree[a] = 1'b1;
		return 8'(a);
	endfunction

	task automatic send_req(input req_t item);
		int gap;
		gap = calm_phase ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.data  <= item;
		req_if.valid <= 1'b1;
		do @(posedge clk); while (!(req_if.valid && req_if.ready));
		@(negedge clk);
		items_sent++;
	endtask

	// Breadth-first random tree rooted at node 0; a few children point at spare or arbitrary nodes.
	task automatic build_tree();
		logic [7:0] todo_addr [$];
		int         todo_depth [$];
		logic [7:0] kid [2];
		logic [7:0] addr;
		int         depth;
		int         depth_cap;
		int         budget;
		int         roll;
		in_tree = '0;
		in_tree[0] = 1'b1;
		thr_seen.delete();
		budget = $urandom_range(2, 40);
		depth_cap = $urandom_range(1, 20);
		todo_addr = {todo_addr, 8'd0};
		todo_depth = {todo_depth, 0};
		while (todo_addr.size() != 0) begin
			addr = todo_addr.pop_front();
			depth = todo_depth.pop_front();
			if (depth >= depth_cap || budget < 2 || (depth != 0 && $urandom_range(0, 3) == 0)) begin
				send_req(make_leaf(addr, 4'($urandom)));
			end else begin
				for (int side = 0; side < 2; side++) begin
					roll = $urandom_range(0, 11);
					if (roll == 0) begin
						kid[side] = 8'($urandom_range(SPARE_LO, SPARE_HI));
					end else if (roll == 1) begin
						kid[side] = 8'($urandom);
					end else begin
						kid[side] = fresh_addr();
						todo_addr = {todo_addr, kid[side]};
						todo_depth = {todo_depth, depth + 1};
						budget--;
					end
				end
				send_req(make_branch(addr, 2'($urandom), pick_threshold(), kid[0], kid[1]));
			end
		end
	endtask

	// A long chain of branches around the depth limit, with an occasional side exit to one leaf.
	task automatic build_chain();
		logic [7:0]         link [$];
		logic [7:0]         exit_leaf;
		logic signed [15:0] thr;
		logic [1:0]         attr;
		int                 len;
		in_tree = '0;
		in_tree[0] = 1'b1;
		thr_seen.delete();
		len = $urandom_range(13, 19);
		link = {link, 8'd0};
		repeat (len) link = {link, fresh_addr()};
		exit_leaf = fresh_addr();
		for (int i = 0; i < len; i++) begin
			thr = pick_threshold();
			attr = 2'($urandom);
			case ($urandom_range(0, 7))
				0: send_req(make_branch(link[i], attr, thr, exit_leaf, link[i+1]));
				1: send_req(make_branch(link[i], attr, thr, link[i+1], exit_leaf));
				default: send_req(make_branch(link[i], attr, thr, link[i+1], link[i+1]));
			endcase
		end
		send_req(make_leaf(link[len], 4'($urandom)));
		send_req(make_leaf(exit_leaf, 4'($urandom)));
	endtask

	initial begin
		int stall;
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = calm_phase ? 0 : $urandom_range(0, 4);
			if (stall != 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
			@(negedge clk);
		end
	end

	initial begin
		int   start_count;
		int   query_count;
		int   phase;
		req_t item;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		items_sent = 0;
		calm_phase = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The root has never been written, so the walk fails at once.
		send_req(make_query(16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff));
		send_req(make_leaf(8'd0, 4'd15));
		send_req(make_query(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)));
		send_req(make_branch(8'd0, 2'd0, 16'sd0, 8'd1, 8'd255));
		send_req(make_leaf(8'd255, 4'd10));
		send_req(make_branch(8'd1, 2'd3, 16'sh8000, 8'd2, 8'd3));
		send_req(make_leaf(8'd3, 4'd5));
		send_req(make_query(16'shffff, 16'($urandom), 16'($urandom), 16'($urandom)));
		// An attribute equal to the threshold goes right.
		send_req(make_query(16'sd0, 16'($urandom), 16'($urandom), 16'($urandom)));
		send_req(make_query(16'sh8000, 16'($urandom), 16'($urandom), 16'sh8000));
		send_req(make_query(16'sh7fff, 16'($urandom), 16'($urandom), 16'($urandom)));
		send_req(make_branch(8'd1, 2'd1, 16'sh7fff, 8'd2, 8'd3));
		send_req(make_query(-16'sd5, 16'sh7fff, 16'($urandom), 16'($urandom)));
		// Left child of node 1 is still unwritten.
		send_req(make_query(-16'sd5, 16'sh7ffe, 16'($urandom), 16'($urandom)));
		// Node 2 points at itself on the left, so a negative attribute loops until the depth limit.
		send_req(make_branch(8'd2, 2'd2, 16'sd0, 8'd2, 8'd3));
		send_req(make_query(16'shffff, 16'sd0, 16'shffff, 16'($urandom)));
		send_req(make_query(16'shffff, 16'sd0, 16'sd0, 16'($urandom)));
		send_req(make_leaf(8'd3, 4'd0));
		send_req(make_query(16'shffff, 16'sd0, 16'sd0, 16'($urandom)));

		start_count = items_sent;
		phase = 0;
		while (items_sent - start_count < RANDOM_ITEMS) begin
			calm_phase = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0)
				build_chain();
			else
				build_tree();
			query_count = $urandom_range(15, 50);
			repeat (query_count) begin
				if ($urandom_range(0, 19) == 0) begin
					item = noise_req();
					item.req_type = REQ_WRITE;
					item.node_addr = 8'($urandom_range(0, SPARE_LO - 1));
				end else begin
					item = make_query(pick_attr(), pick_attr(), pick_attr(), pick_attr());
				end
				send_req(item);
			end
			phase++;
			if (phase == 5) begin
				// Hold the sender until every outstanding result has come back.
				req_if.valid <= 1'b0;
				wait (pending_count == 0);
				@(negedge clk);
			end
		end

		calm_phase = 1'b0;
		req_if.valid <= 1'b0;
		wait (pending_count == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
